// ===== design/rgb_hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types, codes and the restoring-division step of the converter.
// ----------------------------------------------------------------------------
package rgb_hsv_pkg;

   localparam int COMP_W              = 8;
   localparam int QUOT_W              = 16;
   localparam int DIV6_W              = 11;  // six times an 8-bit difference
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   // output of the sort stage
   typedef struct packed {
      logic [COMP_W-1:0] hi;
      logic [COMP_W-1:0] lo;
      sector_type        sector;
      logic signed [COMP_W:0] diff;
   } sort_type;

   // running state of both divisions; the work words hold the dividend bits
   // not yet consumed in their top and the quotient bits already found below
   typedef struct packed {
      logic [COMP_W-1:0] hi;
      logic [DIV6_W-1:0] d6;
      logic [COMP_W-1:0] sat_rem;
      logic [QUOT_W-1:0] sat_work;
      logic [DIV6_W-1:0] hue_rem;
      logic [QUOT_W-1:0] hue_work;
   } div_type;

   // one restoring step of each division
   function automatic div_type div_step(input div_type d);
      div_type            r;
      logic [COMP_W:0]    sat_t;
      logic [DIV6_W:0]    hue_t;
      logic [COMP_W:0]    sat_diff;
      logic [DIV6_W:0]    hue_diff;
      r        = d;
      sat_t    = {d.sat_rem, d.sat_work[QUOT_W-1]};
      hue_t    = {d.hue_rem, d.hue_work[QUOT_W-1]};
      sat_diff = sat_t - {1'b0, d.hi};
      hue_diff = hue_t - {1'b0, d.d6};
      if (sat_t >= {1'b0, d.hi}) begin
         r.sat_rem  = sat_diff[COMP_W-1:0];
         r.sat_work = {d.sat_work[QUOT_W-2:0], 1'b1};
      end else begin
         r.sat_rem  = sat_t[COMP_W-1:0];
         r.sat_work = {d.sat_work[QUOT_W-2:0], 1'b0};
      end
      if (hue_t >= {1'b0, d.d6}) begin
         r.hue_rem  = hue_diff[DIV6_W-1:0];
         r.hue_work = {d.hue_work[QUOT_W-2:0], 1'b1};
      end else begin
         r.hue_rem  = hue_t[DIV6_W-1:0];
         r.hue_work = {d.hue_work[QUOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== design/rgb_hsv_sort.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV sort stage
// Find largest and smallest component, the hue sector and its difference.
// ----------------------------------------------------------------------------
module rgb_hsv_sort
   import rgb_hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [COMP_W-1:0] red,
   input  logic [COMP_W-1:0] green,
   input  logic [COMP_W-1:0] blue,
   output logic              out_valid,
   input  logic              out_ready,
   output sort_type          out_data
);

   logic     valid_ff;
   sort_type data_ff;
   sort_type data_in;
   logic [COMP_W-1:0] lo_rg;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      lo_rg = (green < red) ? green : red;
      data_in.lo = (blue < lo_rg) ? blue : lo_rg;
      // ties go to red, then green
      if (red >= green && red >= blue) begin
         data_in.hi     = red;
         data_in.sector = SECTOR_RED;
         data_in.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         data_in.hi     = green;
         data_in.sector = SECTOR_GREEN;
         data_in.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         data_in.hi     = blue;
         data_in.sector = SECTOR_BLUE;
         data_in.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/rgb_hsv_setup.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV setup stage
// Form the spread, the hue numerator and the initial state of both divisions.
// ----------------------------------------------------------------------------
module rgb_hsv_setup
   import rgb_hsv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sort_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output div_type  out_data
);

   localparam int NUM_W = DIV6_W + 1;
   localparam int SATX_W = COMP_W + QUOT_W;

   logic              valid_ff;
   div_type           data_ff;
   div_type           data_in;
   logic [COMP_W-1:0] delta;
   logic [DIV6_W-1:0] d6;
   logic [DIV6_W-1:0] base;
   logic signed [NUM_W-1:0] num_raw;
   logic signed [NUM_W-1:0] num;
   logic [SATX_W-1:0] sat_x;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      delta = in_data.hi - in_data.lo;
      d6    = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
      case (in_data.sector)
         SECTOR_GREEN: base = {2'b00, delta, 1'b0};
         SECTOR_BLUE:  base = {1'b0, delta, 2'b00};
         default:      base = '0;
      endcase
      num_raw = $signed({1'b0, base}) + NUM_W'(in_data.diff);
      // wrap a negative position by a full turn
      if (num_raw < 0) begin
         num = num_raw + $signed({1'b0, d6});
      end else begin
         num = num_raw;
      end
      // delta * 65535 as delta * 65536 - delta
      sat_x = {delta, {QUOT_W{1'b0}}} - SATX_W'(delta);

      data_in.hi       = in_data.hi;
      data_in.d6       = d6;
      data_in.sat_rem  = sat_x[SATX_W-1:QUOT_W];
      data_in.sat_work = sat_x[QUOT_W-1:0];
      data_in.hue_rem  = num[DIV6_W-1:0];
      data_in.hue_work = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/rgb_hsv_div_stage.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV division stage
// Advance the saturation and hue divisions by four quotient bits.
// ----------------------------------------------------------------------------
module rgb_hsv_div_stage
   import rgb_hsv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         data_in = div_step(data_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/rgb_hsv_to_hsv_top_placeholder.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Zero hue for grey and black pixels, zero saturation for black, and hold
// the finished item for the result channel.
// ----------------------------------------------------------------------------
module rgb_hsv_to_hsv_top_placeholder
   import rgb_hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  div_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QUOT_W-1:0] hue,
   output logic [QUOT_W-1:0] saturation,
   output logic [COMP_W-1:0] brightness
);

   logic              valid_ff;
   logic [QUOT_W-1:0] hue_ff;
   logic [QUOT_W-1:0] hue_in;
   logic [QUOT_W-1:0] sat_ff;
   logic [QUOT_W-1:0] sat_in;
   logic [COMP_W-1:0] bright_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      hue_in = (in_data.d6 == '0) ? '0 : in_data.hue_work;
      sat_in = (in_data.hi == '0) ? '0 : in_data.sat_work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_data.hi;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

// ===== design/rgb_to_hsv_conversion_unit.sv =====
// Throughput: one item per cycle while rsp_tready is high; the pipeline is one sort stage, one
// setup stage, four division stages of four restoring steps each and one output register.
// Each stage holds its own valid bit, so an item is accepted whenever a bubble lies ahead.
// Reset (synchronous, active high) clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
// RGB to HSV conversion unit
// Pipelined pixel converter: brightness, saturation and Q0.16 hue per pixel.
// ----------------------------------------------------------------------------
module rgb_to_hsv_conversion_unit
   import rgb_hsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hue [15:0], saturation [31:16], brightness [39:32]
);

   // sort stage to setup stage
   logic     sort_valid;
   logic     sort_ready;
   sort_type sort_data;

   // division chain: index 0 is the setup stage output, the last the final quotient
   logic    div_valid [DIV_STAGES+1];
   logic    div_ready [DIV_STAGES+1];
   div_type div_data  [DIV_STAGES+1];

   logic [QUOT_W-1:0] hue;
   logic [QUOT_W-1:0] saturation;
   logic [COMP_W-1:0] brightness;

   // stage 1: max, min and hue sector
   rgb_hsv_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (sort_valid),
      .out_ready (sort_ready),
      .out_data  (sort_data)
   );

   // stage 2: spread, wrapped hue numerator and dividends
   rgb_hsv_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sort_valid),
      .in_ready  (sort_ready),
      .in_data   (sort_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // stages 3 to 6: both divisions advance side by side, four bits a stage
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rgb_hsv_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   // stage 7: drop the meaningless quotients of grey and black pixels, hold the item
   rgb_hsv_to_hsv_top_placeholder u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[DIV_STAGES]),
      .in_ready   (div_ready[DIV_STAGES]),
      .in_data    (div_data[DIV_STAGES]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .brightness (brightness)
   );

   assign rsp_tdata = {brightness, saturation, hue};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV conversion unit testbench
// Streams pixels through the converter under four idling patterns, predicts
// brightness, saturation and Q0.16 hue of every accepted pixel with exact
// integer arithmetic and checks each result item in order against it.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rgb_hsv_pkg::*;

   // idling patterns, applied one after another
   typedef enum int {
      PH_NO_IDLE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE
   } idle_phase_t;

   // last field in the lowest bits, so red sits last here
   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } pixel_t;

   typedef struct packed {
      logic [COMP_W-1:0] brightness;
      logic [QUOT_W-1:0] saturation;
      logic [QUOT_W-1:0] hue;
   } hsv_t;

   typedef struct {
      pixel_t pixel;
      hsv_t   hsv;
   } hsv_expect_t;

   localparam int RANDOM_PIXELS   = 1650;
   localparam int SETTLE_CYCLES   = 12;  // pipeline is 7 deep
   localparam int SAT_FULL        = 65535;
   localparam int HUE_TURN        = 65536;
   localparam int SECTORS_IN_TURN = 6;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // hue [15:0], saturation [31:16], brightness [39:32]

   pixel_t      pixel_q[$];        // pixels waiting to be driven
   hsv_expect_t expected_hsv_q[$]; // predictions of accepted pixels, oldest first
   idle_phase_t idle_phase   = PH_NO_IDLE;
   int          queued_count = 0;
   int          sent_count   = 0;
   int          fail_count   = 0;

   rgb_to_hsv_conversion_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10ns clock = ~clock;

   // Exact integer conversion of one pixel. Ties at the maximum go to red,
   // then green, then blue; a negative position in the red sector wraps by
   // a whole turn; black and gray pixels give zero hue and saturation.
   function automatic hsv_t hsv_of_pixel(input pixel_t p);
      hsv_t       res;
      int         r, g, b, hi, lo, delta, offset, diff, num;
      sector_type sector;
      r = int'(p.red);
      g = int'(p.green);
      b = int'(p.blue);
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      res.brightness = hi[COMP_W-1:0];
      res.saturation = '0;
      res.hue        = '0;
      if (hi != 0) begin
         res.saturation = QUOT_W'((delta * SAT_FULL) / hi);
      end
      if (hi != 0 && delta != 0) begin
         if (r == hi) sector = SECTOR_RED;
         else if (g == hi) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED: begin
               offset = 0;
               diff   = g - b;
            end
            SECTOR_GREEN: begin
               offset = 2;
               diff   = b - r;
            end
            default: begin
               offset = 4;
               diff   = r - g;
            end
         endcase
         num = offset * delta + diff;
         if (num < 0) num += SECTORS_IN_TURN * delta;
         // num stays below 6 * delta, so the quotient always fits 16 bits
         res.hue = QUOT_W'((num * HUE_TURN) / (SECTORS_IN_TURN * delta));
      end
      return res;
   endfunction

   function automatic bit roll_idle(input int percent);
      return $urandom_range(99) < percent;
   endfunction

   function automatic int sender_idle_percent(input idle_phase_t ph);
      case (ph)
         PH_SEND_IDLE: return 46;
         PH_BOTH_IDLE: return 24;
         default:      return 0;
      endcase
   endfunction

   function automatic int receiver_stall_percent(input idle_phase_t ph);
      case (ph)
         PH_RECV_STALL: return 46;
         PH_BOTH_IDLE:  return 24;
         default:       return 0;
      endcase
   endfunction

   task automatic report_failure(input string msg);
      $display("check failed at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic queue_pixel(input int r, input int g, input int b);
      pixel_t p;
      p.red   = r[COMP_W-1:0];
      p.green = g[COMP_W-1:0];
      p.blue  = b[COMP_W-1:0];
      pixel_q.push_back(p);
      queued_count++;
   endtask

   // Random pixel, biased towards the corners of the conversion: grays,
   // ties at the maximum, tiny values and full-range spreads.
   task automatic queue_random_pixel();
      int a, b, c;
      a = $urandom_range(255);
      b = $urandom_range(255);
      c = $urandom_range(255);
      case ($urandom_range(9))
         0: queue_pixel(a, a, a);
         1: begin
            b = $urandom_range(a);
            case ($urandom_range(2))
               0:       queue_pixel(a, a, b);
               1:       queue_pixel(b, a, a);
               default: queue_pixel(a, b, a);
            endcase
         end
         2: queue_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
         3: begin
            case ($urandom_range(5))
               0:       queue_pixel(255, 0, c);
               1:       queue_pixel(255, c, 0);
               2:       queue_pixel(0, 255, c);
               3:       queue_pixel(c, 255, 0);
               4:       queue_pixel(0, c, 255);
               default: queue_pixel(c, 0, 255);
            endcase
         end
         default: queue_pixel(a, b, c);
      endcase
   endtask

   // Driver: predict each pixel on acceptance, then either advance to the
   // next pending pixel or drop valid for an idle cycle. Valid gets exactly
   // one assignment per edge at most.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_hsv_q.push_back('{pixel: pixel_t'(req_tdata),
                                       hsv: hsv_of_pixel(pixel_t'(req_tdata))});
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_q.size() > 0 && !roll_idle(sender_idle_percent(idle_phase))) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pixel_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every accepted result item with the oldest prediction,
   // field by field, then pick the ready level for the next cycle.
   always @(posedge clock) begin
      hsv_t        got;
      hsv_expect_t exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = hsv_t'(rsp_tdata);
         if (expected_hsv_q.size() == 0) begin
            report_failure($sformatf("unexpected result item %h", rsp_tdata));
         end else begin
            exp_item = expected_hsv_q.pop_front();
            if (got.hue !== exp_item.hsv.hue)
               report_failure($sformatf("pixel r%0d g%0d b%0d: hue %0d, expected %0d",
                  exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                  got.hue, exp_item.hsv.hue));
            if (got.saturation !== exp_item.hsv.saturation)
               report_failure($sformatf("pixel r%0d g%0d b%0d: saturation %0d, expected %0d",
                  exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                  got.saturation, exp_item.hsv.saturation));
            if (got.brightness !== exp_item.hsv.brightness)
               report_failure($sformatf("pixel r%0d g%0d b%0d: brightness %0d, expected %0d",
                  exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                  got.brightness, exp_item.hsv.brightness));
         end
      end
      rsp_tready <= !roll_idle(receiver_stall_percent(idle_phase));
   end

   // Stimulus and end of run
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed pixels: black, grays, white, primaries, ties and wrap-around
      idle_phase = PH_NO_IDLE;
      queue_pixel(0, 0, 0);
      queue_pixel(1, 1, 1);
      queue_pixel(128, 128, 128);
      queue_pixel(255, 255, 255);
      queue_pixel(255, 0, 0);
      queue_pixel(0, 255, 0);
      queue_pixel(0, 0, 255);
      queue_pixel(1, 0, 0);
      queue_pixel(0, 1, 0);
      queue_pixel(0, 0, 1);
      queue_pixel(255, 255, 0);   // red and green tie, red wins
      queue_pixel(0, 255, 255);   // green and blue tie, green wins
      queue_pixel(255, 0, 255);   // red and blue tie, negative position wraps
      queue_pixel(255, 0, 1);     // just short of a full turn
      queue_pixel(255, 1, 0);
      queue_pixel(254, 255, 0);
      queue_pixel(0, 254, 255);
      queue_pixel(255, 254, 255);
      queue_pixel(170, 85, 0);
      queue_pixel(2, 1, 0);
      queue_pixel(255, 128, 1);

      // random pixels in four idling phases; switch only once every queued pixel is sent
      for (int ph = PH_NO_IDLE; ph <= PH_BOTH_IDLE; ph++) begin
         while (sent_count != queued_count) @(negedge clock);
         idle_phase = idle_phase_t'(ph);
         repeat (RANDOM_PIXELS / 4) queue_random_pixel();
      end

      // hold until every pixel is in and every result is out
      while (sent_count != queued_count) @(negedge clock);
      while (expected_hsv_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_hsv_q.size() != 0)
         report_failure($sformatf("%0d result items never arrived", expected_hsv_q.size()));

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/rgb_hsv_pkg.sv
design/rgb_hsv_sort.sv
design/rgb_hsv_setup.sv
design/rgb_hsv_div_stage.sv
design/rgb_hsv_to_hsv_top_placeholder.sv
design/rgb_to_hsv_conversion_unit.sv
dv/testbench.sv
